/* rtl/hll_pkg.sv */
// ----------------------------------------------------------------------------
// HyperLogLog sketch package
// Shared types and fixed constants for the sketch unit and its parts.
// ----------------------------------------------------------------------------
package hll_pkg;

  localparam int HASH_W   = 64;
  localparam int INDEX_W  = 14;
  localparam int VALUE_W  = 6;
  localparam int SUM_W    = 63;
  localparam int ZCNT_W   = 15;
  localparam int PREC_W   = 4;
  localparam int MIN_PREC = 4;

  localparam logic [PREC_W-1:0] PREC_RESET = 4'd14;
  localparam logic [SUM_W-1:0]  SUM_MAX    = '1;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_MERGE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Classified command as it sits in the queue (the index travels beside it).
  typedef struct packed {
    op_t               op;
    logic              err;
    logic [VALUE_W-1:0] val;
  } cmd_ctl_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_RMW,
    BK_QUERY,
    BK_QSUM,
    BK_CLEAR,
    BK_REPORT
  } bk_state_t;

endpackage

/* rtl/hll_if.sv */
// ----------------------------------------------------------------------------
// HyperLogLog sketch channels
// Command and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hll_cmd_if import hll_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [HASH_W-1:0]  hash;
  logic [INDEX_W-1:0] reg_index;
  logic [VALUE_W-1:0] reg_value;

  modport source(output valid, op, hash, reg_index, reg_value, input ready);
  modport sink(input valid, op, hash, reg_index, reg_value, output ready);
endinterface

interface hll_rsp_if import hll_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  inverse_sum;
  logic [ZCNT_W-1:0] zero_registers;
  logic              index_error;

  modport source(output valid, inverse_sum, zero_registers, index_error, input ready);
  modport sink(input valid, inverse_sum, zero_registers, index_error, output ready);
endinterface

/* rtl/hll_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hll_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/hll_front.sv */
// ----------------------------------------------------------------------------
// HyperLogLog front end
// Accepts command words, clamps the precision and classifies each word:
// register index, rank or merge value, and the merge range check.
// ----------------------------------------------------------------------------
module hll_front import hll_pkg::*; #(
  parameter int MAX_PRECISION = 14
) (
  input  logic [PREC_W-1:0]        precision,
  input  logic                     store_init,
  input  q_stat_t                  q_stat,
  hll_cmd_if.sink                  cmd,
  output logic                     push,
  output cmd_ctl_t                 push_ctl,
  output logic [MAX_PRECISION-1:0] push_idx
);

  localparam int PW = 5;

  logic [PW-1:0]     p;
  logic [31:0]       active;
  logic [31:0]       active_m1;
  logic [31:0]       merge_ext;
  logic [HASH_W-1:0] top_bits;
  logic [HASH_W-1:0] rest;
  logic [7:0]        byte_nz;
  logic [2:0]        byte_lz [8];
  logic [5:0]        lz;
  logic              found;
  logic [6:0]        rank;
  op_t               op;

  assign op = op_t'(cmd.op);

  always_comb begin
    if (precision < PREC_W'(MIN_PREC)) begin
      p = PW'(MIN_PREC);
    end else if (PW'(precision) > PW'(MAX_PRECISION)) begin
      p = PW'(MAX_PRECISION);
    end else begin
      p = PW'(precision);
    end
  end

  assign active    = 32'd1 << p;
  assign active_m1 = active - 32'd1;
  assign merge_ext = 32'(cmd.reg_index);
  assign top_bits  = cmd.hash >> (7'd64 - {2'b00, p});
  assign rest      = cmd.hash << p;

  // Leading-zero count: per-byte encoders, then a search for the top nonzero byte.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_nz[b] = |rest[b*8 +: 8];
      byte_lz[b] = 3'd0;
      for (int k = 0; k < 8; k++) begin
        if (rest[b*8+k]) begin
          byte_lz[b] = 3'(7 - k);
        end
      end
    end
    found = 1'b0;
    lz    = 6'd0;
    for (int b = 7; b >= 0; b--) begin
      if (!found && byte_nz[b]) begin
        found = 1'b1;
        lz    = 6'((7 - b) * 8) + {3'b000, byte_lz[b]};
      end
    end
  end

  // When the bits below the index are all zero the rank is 65 minus the precision.
  assign rank = (rest == '0) ? (7'd65 - {2'b00, p}) : ({1'b0, lz} + 7'd1);

  assign cmd.ready = !q_stat.full && !store_init;
  assign push      = cmd.valid && cmd.ready;

  always_comb begin
    push_ctl.op  = op;
    push_ctl.err = 1'b0;
    push_ctl.val = '0;
    push_idx     = '0;
    case (op)
      OP_UPDATE: begin
        push_ctl.val = rank[VALUE_W-1:0];
        push_idx     = top_bits[MAX_PRECISION-1:0];
      end
      OP_MERGE: begin
        push_ctl.err = (merge_ext >= active);
        push_ctl.val = cmd.reg_value;
        push_idx     = merge_ext[MAX_PRECISION-1:0];
      end
      OP_QUERY: begin
        // The back end sweeps from zero up to this last active index.
        push_idx = active_m1[MAX_PRECISION-1:0];
      end
      default: begin
        push_idx = '0;
      end
    endcase
  end

endmodule

/* rtl/hll_cmd_queue.sv */
// ----------------------------------------------------------------------------
// HyperLogLog command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hll_cmd_queue import hll_pkg::*; #(
  parameter int WIDTH = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign pop_data   = slot[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/hll_back.sv */
// ----------------------------------------------------------------------------
// HyperLogLog back end
// Owns the rank store. Runs read-modify-write for updates and merges,
// sweeps the store for queries and clears, and holds the response register.
// ----------------------------------------------------------------------------
module hll_back import hll_pkg::*; #(
  parameter int MAX_PRECISION = 14,
  parameter int FRAC_BITS     = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     head_valid,
  input  cmd_ctl_t                 head_ctl,
  input  logic [MAX_PRECISION-1:0] head_idx,
  output logic                     pop,
  output logic                     store_init,
  hll_rsp_if.source                rsp
);

  localparam int AW       = MAX_PRECISION;
  localparam int DEPTH    = 1 << AW;
  localparam int CW       = AW + 1;
  localparam int ACC_W    = HASH_W + AW + 1;
  localparam int LO_SHIFT = HASH_W - FRAC_BITS;
  localparam int HI_W     = ACC_W - LO_SHIFT;
  localparam int CMP_W    = (HI_W > SUM_W + 1) ? HI_W : SUM_W + 1;

  bk_state_t          state;
  bk_state_t          state_next;
  cmd_ctl_t           cur_ctl;
  logic [AW-1:0]      cur_idx;
  logic [AW-1:0]      sweep_addr;
  logic               issue_done;
  logic               rd_pend;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   term;
  logic [CW-1:0]      zcnt;
  logic [31:0]        zcnt_ext;
  logic [CMP_W-1:0]   hi_ext;
  logic [SUM_W-1:0]   sat_sum;
  logic [SUM_W-1:0]   sum_res;
  logic               out_load;
  logic               out_valid;
  logic [SUM_W-1:0]   out_sum;
  logic [ZCNT_W-1:0]  out_zero;
  logic               out_err;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  hll_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Each register contributes 2^(64 - rank) in units of 2^-64.
  assign term     = ACC_W'(1) << (7'd64 - {1'b0, ram_rdata});
  assign hi_ext   = CMP_W'(acc >> LO_SHIFT);
  assign sat_sum  = (hi_ext > CMP_W'(SUM_MAX)) ? SUM_MAX : hi_ext[SUM_W-1:0];
  assign zcnt_ext = 32'(zcnt);

  always_comb begin
    state_next = state;
    case (state)
      BK_INIT: begin
        if (&sweep_addr) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid) begin
          case (head_ctl.op)
            OP_UPDATE: state_next = BK_RMW;
            OP_MERGE:  state_next = head_ctl.err ? BK_REPORT : BK_RMW;
            OP_QUERY:  state_next = BK_QUERY;
            default:   state_next = BK_CLEAR;
          endcase
        end
      end
      BK_RMW: begin
        state_next = BK_REPORT;
      end
      BK_QUERY: begin
        if (issue_done && !rd_pend) begin
          state_next = BK_QSUM;
        end
      end
      BK_QSUM: begin
        state_next = BK_REPORT;
      end
      BK_CLEAR: begin
        if (&sweep_addr) begin
          state_next = BK_REPORT;
        end
      end
      BK_REPORT: begin
        if (!out_valid || rsp.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = sweep_addr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = head_idx;
    out_load   = 1'b0;
    store_init = (state == BK_INIT);
    case (state)
      BK_INIT, BK_CLEAR: begin
        ram_we = 1'b1;
      end
      BK_IDLE: begin
        pop    = head_valid;
        ram_re = head_valid && ((head_ctl.op == OP_UPDATE) ||
                                ((head_ctl.op == OP_MERGE) && !head_ctl.err));
      end
      BK_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = cur_idx;
        ram_wdata = (cur_ctl.val > ram_rdata) ? cur_ctl.val : ram_rdata;
      end
      BK_QUERY: begin
        ram_re    = !issue_done;
        ram_raddr = sweep_addr;
      end
      BK_REPORT: begin
        out_load = !out_valid || rsp.ready;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_INIT;
      sweep_addr <= '0;
      issue_done <= 1'b0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == BK_QUERY) && ram_re;
      if (pop) begin
        sweep_addr <= '0;
        issue_done <= 1'b0;
      end else if (state == BK_INIT || state == BK_CLEAR) begin
        sweep_addr <= sweep_addr + AW'(1);
      end else if (state == BK_QUERY && ram_re) begin
        if (sweep_addr == cur_idx) begin
          issue_done <= 1'b1;
        end else begin
          sweep_addr <= sweep_addr + AW'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_ctl <= head_ctl;
      cur_idx <= head_idx;
      acc     <= '0;
      zcnt    <= '0;
    end else if (rd_pend) begin
      acc <= acc + term;
      if (ram_rdata == '0) begin
        zcnt <= zcnt + CW'(1);
      end
    end
    if (state == BK_QSUM) begin
      sum_res <= sat_sum;
    end
    if (out_load) begin
      out_sum  <= (cur_ctl.op == OP_QUERY) ? sum_res : '0;
      out_zero <= (cur_ctl.op == OP_QUERY) ? zcnt_ext[ZCNT_W-1:0] : '0;
      out_err  <= cur_ctl.err;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.inverse_sum    = out_sum;
  assign rsp.zero_registers = out_zero;
  assign rsp.index_error    = out_err;

endmodule

/* rtl/hyperloglog_sketch_unit.sv */
// ----------------------------------------------------------------------------
// HyperLogLog sketch unit
// Rank store and raw inverse sum of a HyperLogLog cardinality sketch.
// ----------------------------------------------------------------------------
//   channel  | dir | word
//   ---------+-----+-----------------------------------------------------
//   cmd      | in  | op, hash, reg_index, reg_value
//   rsp      | out | inverse_sum, zero_registers, index_error
//   cfg      | in  | cfg_write, cfg_data (precision)
//
// Update and in-range merge run three steps in the back end: a store read,
// a write of the maximum, and the response load; a rejected merge skips the
// read and write. Query sweeps the active registers through the single
// store read port; clear sweeps all 2^MAX_PRECISION registers. After reset
// the store is swept to zero while cmd.ready stays low. A two-word queue
// lets the front end accept up to two words while the back end or rsp stalls.
// ----------------------------------------------------------------------------
module hyperloglog_sketch_unit import hll_pkg::*; #(
  parameter int MAX_PRECISION = 14,
  parameter int FRAC_BITS     = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [PREC_W-1:0] cfg_data,
  hll_cmd_if.sink           cmd,
  hll_rsp_if.source         rsp
);

  localparam int QW = $bits(cmd_ctl_t) + MAX_PRECISION;

  logic [PREC_W-1:0]        precision;
  logic                     store_init;
  q_stat_t                  q_stat;
  logic                     push;
  cmd_ctl_t                 push_ctl;
  logic [MAX_PRECISION-1:0] push_idx;
  logic                     pop;
  logic [QW-1:0]            head_data;
  cmd_ctl_t                 head_ctl;
  logic [MAX_PRECISION-1:0] head_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= PREC_RESET;
    end else if (cfg_write) begin
      precision <= cfg_data;
    end
  end

  hll_front #(
    .MAX_PRECISION(MAX_PRECISION)
  ) u_front (
    .precision (precision),
    .store_init(store_init),
    .q_stat    (q_stat),
    .cmd       (cmd),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_idx  (push_idx)
  );

  hll_cmd_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_ctl, push_idx}),
    .pop      (pop),
    .pop_data (head_data),
    .stat     (q_stat)
  );

  assign {head_ctl, head_idx} = head_data;

  hll_back #(
    .MAX_PRECISION(MAX_PRECISION),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_stat.valid),
    .head_ctl  (head_ctl),
    .head_idx  (head_idx),
    .pop       (pop),
    .store_init(store_init),
    .rsp       (rsp)
  );

endmodule

/* rtl/hll_checker.sv */
// ----------------------------------------------------------------------------
// HyperLogLog sketch checker
// Port-level checks on the sketch unit, attached with a bind.
// ----------------------------------------------------------------------------
module hll_checker import hll_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [SUM_W-1:0]  inverse_sum,
  input logic [ZCNT_W-1:0] zero_registers,
  input logic              index_error
);

  // The store is being swept right after reset, so no word may be taken.
  a_init_blocks: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("command accepted during the reset clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(inverse_sum) && $stable(zero_registers) && $stable(index_error))
    else $error("response word changed while stalled");

  // A rejected merge is never a query, so its sum and zero count are empty.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && index_error |-> (inverse_sum == '0) && (zero_registers == '0))
    else $error("index error response carries query data");

  a_cmd_input_known: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !$isunknown(rsp_valid))
    else $error("response valid unknown after an accepted command");

endmodule

bind hyperloglog_sketch_unit hll_checker u_hll_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .inverse_sum   (rsp.inverse_sum),
  .zero_registers(rsp.zero_registers),
  .index_error   (rsp.index_error)
);
